>>> src/lsif_pkg.sv
`default_nettype none

package lsif_pkg;

    localparam int TAPS  = 80;
    localparam int TAP_W = $clog2(TAPS);
    localparam int PC_W  = 4;

    // Sample and weight word, error word and the exact update product.
    localparam int DATA_W = 16;
    localparam int ACC_W  = 32;
    localparam int PROD_W = ACC_W + DATA_W;

    typedef logic [PC_W-1:0]  pc_t;
    typedef logic [TAP_W-1:0] tap_idx_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_LOOP_CNT,
        COND_WAIT_SAMPLE,
        COND_WAIT_OUT
    } cond_t;

    // Datapath controls driven by the current microinstruction.
    typedef struct packed {
        logic in_ready;
        logic clr;
        logic issue_mac;
        logic issue_upd;
        logic err_load;
    } ctrl_t;

    // Status from the datapath that the jump conditions test.
    typedef struct packed {
        logic cnt_last;
        logic sample_go;
        logic out_busy;
    } status_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        pc_t   target;
    } uword_t;

    localparam pc_t PC_CLEAR  = 4'd0;
    localparam pc_t PC_IDLE   = 4'd1;
    localparam pc_t PC_MAC    = 4'd2;
    localparam pc_t PC_DRAIN0 = 4'd3;
    localparam pc_t PC_DRAIN1 = 4'd4;
    localparam pc_t PC_ERR    = 4'd5;
    localparam pc_t PC_UPD    = 4'd6;
    localparam pc_t PC_WB0    = 4'd7;
    localparam pc_t PC_WB1    = 4'd8;
    localparam pc_t PC_WB2    = 4'd9;

    localparam ctrl_t CTRL_NOP  = '{default: 1'b0};
    localparam ctrl_t CTRL_CLR  = '{clr: 1'b1, default: 1'b0};
    localparam ctrl_t CTRL_IDLE = '{in_ready: 1'b1, default: 1'b0};
    localparam ctrl_t CTRL_MAC  = '{issue_mac: 1'b1, default: 1'b0};
    localparam ctrl_t CTRL_ERR  = '{err_load: 1'b1, default: 1'b0};
    localparam ctrl_t CTRL_UPD  = '{issue_upd: 1'b1, default: 1'b0};

    // Microprogram. Each word jumps to its target when its condition holds,
    // and otherwise falls through to the next word.
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        unique case (pc)
            PC_CLEAR:  w = '{CTRL_CLR,  COND_LOOP_CNT,    PC_CLEAR};
            PC_IDLE:   w = '{CTRL_IDLE, COND_WAIT_SAMPLE, PC_IDLE};
            PC_MAC:    w = '{CTRL_MAC,  COND_LOOP_CNT,    PC_MAC};
            PC_DRAIN0: w = '{CTRL_NOP,  COND_NEXT,        PC_IDLE};
            PC_DRAIN1: w = '{CTRL_NOP,  COND_NEXT,        PC_IDLE};
            PC_ERR:    w = '{CTRL_ERR,  COND_WAIT_OUT,    PC_ERR};
            PC_UPD:    w = '{CTRL_UPD,  COND_LOOP_CNT,    PC_UPD};
            PC_WB0:    w = '{CTRL_NOP,  COND_NEXT,        PC_IDLE};
            PC_WB1:    w = '{CTRL_NOP,  COND_NEXT,        PC_IDLE};
            PC_WB2:    w = '{CTRL_NOP,  COND_JUMP,        PC_IDLE};
            default:   w = '{CTRL_NOP,  COND_JUMP,        PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/lsif_sequencer.sv
`default_nettype none

module lsif_sequencer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lsif_pkg::status_t status,
    output lsif_pkg::ctrl_t        ctrl
);

    lsif_pkg::pc_t    pc_reg;
    lsif_pkg::pc_t    pc_next;
    lsif_pkg::uword_t uword;
    logic             take_jump;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= lsif_pkg::PC_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        uword = lsif_pkg::ucode_rom(pc_reg);
        ctrl  = uword.ctrl;
        unique case (uword.cond)
            lsif_pkg::COND_NEXT:        take_jump = 1'b0;
            lsif_pkg::COND_JUMP:        take_jump = 1'b1;
            lsif_pkg::COND_LOOP_CNT:    take_jump = !status.cnt_last;
            lsif_pkg::COND_WAIT_SAMPLE: take_jump = !status.sample_go;
            lsif_pkg::COND_WAIT_OUT:    take_jump = status.out_busy;
            default:                    take_jump = 1'b1;
        endcase
        pc_next = take_jump ? uword.target : lsif_pkg::pc_t'(pc_reg + 1'b1);
    end

endmodule

`default_nettype wire

>>> src/lsif_datapath.sv
`default_nettype none

module lsif_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lsif_pkg::ctrl_t      ctrl,
    output lsif_pkg::status_t         status,
    input  wire logic                 in_valid,
    input  wire logic                 req_type,
    input  wire logic [6:0]           coef_index,
    input  wire logic signed [15:0]   coef_value,
    input  wire logic signed [15:0]   sample_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [15:0]        error_out,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [5:0]           cfg_data
);

    localparam int DW = lsif_pkg::DATA_W;
    localparam int AW = lsif_pkg::ACC_W;
    localparam int PW = lsif_pkg::PROD_W;
    localparam lsif_pkg::tap_idx_t LAST_IDX = lsif_pkg::tap_idx_t'(lsif_pkg::TAPS - 1);

    logic signed [DW-1:0] ref_mem [lsif_pkg::TAPS];
    logic signed [DW-1:0] w_mem   [lsif_pkg::TAPS];
    logic signed [DW-1:0] d_mem   [lsif_pkg::TAPS];

    logic signed [DW-1:0] ref_q_reg;
    logic signed [DW-1:0] w_q_reg;
    logic signed [DW-1:0] d_q_reg;

    logic [5:0]           step_shift_reg;
    lsif_pkg::tap_idx_t   cnt_reg;
    lsif_pkg::tap_idx_t   head_reg;
    lsif_pkg::tap_idx_t   daddr_reg;
    lsif_pkg::tap_idx_t   head_next;

    logic                 mac_v1_reg;
    logic                 mac_v2_reg;
    logic                 upd_v1_reg;
    logic                 upd_v2_reg;
    logic                 upd_v3_reg;
    lsif_pkg::tap_idx_t   idx1_reg;
    lsif_pkg::tap_idx_t   idx2_reg;
    lsif_pkg::tap_idx_t   idx3_reg;

    logic [AW-1:0]        prod_reg;
    logic [AW-1:0]        acc_reg;
    logic signed [AW-1:0] err_reg;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] fl_reg;
    logic                 frac_reg;
    logic signed [DW-1:0] w1_reg;
    logic signed [DW-1:0] w2_reg;

    logic                 out_valid_reg;
    logic signed [DW-1:0] out_data_reg;

    logic                 sample_load;
    logic                 coef_write;
    logic                 step;
    logic                 err_fire;
    logic signed [DW:0]   diff;
    logic signed [2*DW:0] mac_prod;
    logic signed [PW:0]   tsum;
    logic signed [DW-1:0] w_new;

    assign sample_load = ctrl.in_ready && in_valid && req_type;
    assign coef_write  = ctrl.in_ready && in_valid && !req_type
                         && ({1'b0, coef_index} < 8'(lsif_pkg::TAPS));
    assign step        = ctrl.clr || ctrl.issue_mac || ctrl.issue_upd;
    assign err_fire    = ctrl.err_load && !status.out_busy;
    assign head_next   = (head_reg == '0) ? LAST_IDX
                                          : lsif_pkg::tap_idx_t'(head_reg - 1'b1);

    assign status.cnt_last  = (cnt_reg == LAST_IDX);
    assign status.sample_go = in_valid && req_type;
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign error_out = out_data_reg;

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (coef_write)
        begin
            ref_mem[lsif_pkg::tap_idx_t'(coef_index)] <= coef_value;
        end
        if (ctrl.clr)
        begin
            w_mem[cnt_reg] <= '0;
            d_mem[cnt_reg] <= '0;
        end
        else
        begin
            if (upd_v3_reg)
            begin
                w_mem[idx3_reg] <= w_new;
            end
            if (sample_load)
            begin
                d_mem[head_next] <= sample_in;
            end
        end
        ref_q_reg <= ref_mem[cnt_reg];
        w_q_reg   <= w_mem[cnt_reg];
        d_q_reg   <= d_mem[daddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_shift_reg <= 6'd40;
            cnt_reg        <= '0;
            head_reg       <= '0;
            daddr_reg      <= '0;
            mac_v1_reg     <= 1'b0;
            mac_v2_reg     <= 1'b0;
            upd_v1_reg     <= 1'b0;
            upd_v2_reg     <= 1'b0;
            upd_v3_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                step_shift_reg <= cfg_data;
            end
            if (step)
            begin
                cnt_reg <= status.cnt_last ? '0 : lsif_pkg::tap_idx_t'(cnt_reg + 1'b1);
            end
            // The tap address runs around the circular delay line and comes
            // back to the head after a full pass.
            if (sample_load)
            begin
                head_reg  <= head_next;
                daddr_reg <= head_next;
            end
            else if (ctrl.issue_mac || ctrl.issue_upd)
            begin
                daddr_reg <= (daddr_reg == LAST_IDX) ? '0
                             : lsif_pkg::tap_idx_t'(daddr_reg + 1'b1);
            end
            mac_v1_reg <= ctrl.issue_mac;
            mac_v2_reg <= mac_v1_reg;
            upd_v1_reg <= ctrl.issue_upd;
            upd_v2_reg <= upd_v1_reg;
            upd_v3_reg <= upd_v2_reg;
            if (err_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Desired minus output equals the sum of (reference - weight) * tap,
    // modulo 2^32, so one pass forms the error directly.
    always_comb
    begin
        diff     = {ref_q_reg[DW-1], ref_q_reg} - {w_q_reg[DW-1], w_q_reg};
        mac_prod = diff * d_q_reg;
    end

    always_comb
    begin
        tsum = {{(PW + 1 - DW){w2_reg[DW-1]}}, w2_reg} + {fl_reg[PW-1], fl_reg};
        // Floor plus a fraction, when negative, rounds up to truncate toward zero.
        if (frac_reg && tsum[PW])
        begin
            tsum = tsum + 1'b1;
        end
        if (tsum > (PW + 1)'(32767))
        begin
            w_new = 16'sh7FFF;
        end
        else if (tsum < -(PW + 1)'(32768))
        begin
            w_new = -16'sh8000;
        end
        else
        begin
            w_new = tsum[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= cnt_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        if (mac_v1_reg)
        begin
            prod_reg <= mac_prod[AW-1:0];
        end
        if (sample_load)
        begin
            acc_reg <= '0;
        end
        else if (mac_v2_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (err_fire)
        begin
            err_reg      <= acc_reg;
            out_data_reg <= acc_reg[AW-2:AW-1-DW];
        end
        p_reg    <= err_reg * d_q_reg;
        w1_reg   <= w_q_reg;
        fl_reg   <= p_reg >>> step_shift_reg;
        frac_reg <= |(p_reg & ~({PW{1'b1}} << step_shift_reg));
        w2_reg   <= w1_reg;
    end

endmodule

`default_nettype wire

>>> src/lms_system_identification_filter_unit.sv
`default_nettype none

// LMS adaptive FIR in system-identification form with 80 taps. An input
// transaction with req_type 0 loads one reference coefficient; one with
// req_type 1 takes a sample and yields one error_out transaction. A sample
// occupies the unit from its input step to its return to idle: one pass of
// the shared multiply-accumulate forms the error, a second pass runs the
// weight update through a multiply, shift and saturate pipeline, and drain
// steps end each pass. The next input is taken while a result waits on the
// output register; a sample stalls only at its error step if the previous
// result is still not taken. After reset a clearing pass zeroes the delay
// line and the weights before the first input transaction is taken;
// configuration writes are taken at any time. All reference coefficients a
// sample uses must have been written first.
module lms_system_identification_filter_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic [6:0]         coef_index,
    input  wire logic signed [15:0] coef_value,
    input  wire logic signed [15:0] sample_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      error_out,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         cfg_data
);

    lsif_pkg::ctrl_t   ctrl;
    lsif_pkg::status_t status;

    lsif_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    lsif_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .in_valid   (in_valid),
        .req_type   (req_type),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .error_out  (error_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    assign in_ready = ctrl.in_ready;

    // A sample transaction starts the filter passes, so input closes.
    a_sample_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type) |=> !in_ready)
        else $error("input still open after a sample transaction");

    // A coefficient write keeps the unit idle.
    a_coef_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !req_type) |=> in_ready)
        else $error("coefficient write left the idle step");

    // A new result appears while the update pass runs, never at idle.
    a_result_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (ctrl.issue_upd && !in_ready))
        else $error("result appeared outside the update pass");

endmodule

`default_nettype wire
